// ----- rtl/core/rwpc_pkg.sv -----
package rwpc_pkg;

    // default sizes
    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_BITS_DEF   = 16;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_LEFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_RIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_TOP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_BOTTOM = 2'd3;

    // window reset values
    localparam int WIN_LEFT_RST   = -100;
    localparam int WIN_RIGHT_RST  = 100;
    localparam int WIN_TOP_RST    = 100;
    localparam int WIN_BOTTOM_RST = -100;

    // clip sides, in pass order
    localparam int SIDE_LEFT   = 0;
    localparam int SIDE_RIGHT  = 1;
    localparam int SIDE_TOP    = 2;
    localparam int SIDE_BOTTOM = 3;
    localparam int NUM_SIDES   = 4;

    // flags that go with each beat between stages
    typedef struct packed {
        logic has_vtx;
        logic is_end;
        logic empty;
        logic ovf;
    } tok_flags_t;

endpackage

// ----- rtl/core/rwpc_ram.sv -----
module rwpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/rwpc_cell.sv -----
module rwpc_cell #(
    parameter int MAX_V = rwpc_pkg::MAX_VERTICES_DEF,
    parameter int CB    = rwpc_pkg::COORD_BITS_DEF,
    parameter int SIDE  = rwpc_pkg::SIDE_LEFT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic signed [CB-1:0] win,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rwpc_pkg::tok_flags_t in_flags,
    input  logic signed [CB-1:0] in_x,
    input  logic signed [CB-1:0] in_y,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rwpc_pkg::tok_flags_t out_flags,
    output logic signed [CB-1:0] out_x,
    output logic signed [CB-1:0] out_y
);

    localparam int  NW     = 2 * (CB + 1);
    localparam int  CW     = $clog2(MAX_V + 1);
    localparam int  SW     = $clog2(NW + 1);
    localparam bit  AXIS_X = (SIDE == rwpc_pkg::SIDE_LEFT) || (SIDE == rwpc_pkg::SIDE_RIGHT);
    localparam bit  GE     = (SIDE == rwpc_pkg::SIDE_LEFT) || (SIDE == rwpc_pkg::SIDE_BOTTOM);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_MUL   = 10'b0000000010,
        S_DINIT = 10'b0000000100,
        S_DIV   = 10'b0000001000,
        S_FIX   = 10'b0000010000,
        S_EMITX = 10'b0000100000,
        S_EMITP = 10'b0001000000,
        S_ENDCK = 10'b0010000000,
        S_CLOSE = 10'b0100000000,
        S_SEND  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [CB-1:0] cur_x_reg, cur_y_reg, cur_x_next, cur_y_next;
    logic signed [CB-1:0] s_x_reg, s_y_reg, s_x_next, s_y_next;
    logic signed [CB-1:0] first_x_reg, first_y_reg, first_x_next, first_y_next;
    logic signed [CB-1:0] last_x_reg, last_y_reg, last_x_next, last_y_next;
    logic signed [CB-1:0] xp_x_reg, xp_y_reg, xp_x_next, xp_y_next;
    logic                 have_prev_reg, have_prev_next;
    logic                 end_reg, end_next;
    logic                 inovf_reg, inovf_next;
    logic                 p_in_reg, p_in_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 ovf_reg, ovf_next;
    logic signed [NW-1:0] prod_reg, prod_next;
    logic signed [CB:0]   den_reg, den_next;
    logic signed [CB-1:0] pb_reg, pb_next;
    logic [CB+1:0]        rem_reg, rem_next;
    logic [NW-1:0]        quo_reg, quo_next;
    logic [CB:0]          dmag_reg, dmag_next;
    logic                 qneg_reg, qneg_next;
    logic [SW-1:0]        step_reg, step_next;
    logic                 out_valid_reg, out_valid_next;
    rwpc_pkg::tok_flags_t out_flags_reg, out_flags_next;
    logic signed [CB-1:0] out_x_reg, out_y_reg, out_x_next, out_y_next;

    // combinational helpers
    logic signed [CB-1:0] tok_axis, old_axis, pa, sa, pb, sb;
    logic                 tok_in, old_in, out_free;
    logic signed [CB:0]   d_wa, d_b, d_a;
    logic [CB+1:0]        rem_sh;
    logic                 rem_ge;
    logic signed [CB+1:0] q_s, s_v;
    logic signed [CB-1:0] cand_x, cand_y;

    always_comb
    begin
        tok_axis = AXIS_X ? in_x : in_y;
        old_axis = AXIS_X ? cur_x_reg : cur_y_reg;
        tok_in   = GE ? (tok_axis >= win) : (tok_axis <= win);
        old_in   = GE ? (old_axis >= win) : (old_axis <= win);
        pa       = AXIS_X ? cur_x_reg : cur_y_reg;
        pb       = AXIS_X ? cur_y_reg : cur_x_reg;
        sa       = AXIS_X ? s_x_reg : s_y_reg;
        sb       = AXIS_X ? s_y_reg : s_x_reg;
        d_wa     = (CB+1)'(win) - (CB+1)'(pa);
        d_b      = (CB+1)'(sb) - (CB+1)'(pb);
        d_a      = (CB+1)'(sa) - (CB+1)'(pa);
        rem_sh   = {rem_reg[CB:0], quo_reg[NW-1]};
        rem_ge   = rem_sh >= {1'b0, dmag_reg};
        q_s      = qneg_reg ? -$signed(quo_reg[CB+1:0]) : $signed(quo_reg[CB+1:0]);
        s_v      = q_s + (CB+2)'(pb_reg);
        if (s_v < 0)
        begin
            s_v = s_v + (CB+2)'(1);
        end
        out_free = !out_valid_reg || out_ready;
    end

    // pick the vertex that an emit state hands on
    always_comb
    begin
        case (state_reg)
            S_EMITX:
            begin
                cand_x = xp_x_reg;
                cand_y = xp_y_reg;
            end
            S_CLOSE:
            begin
                cand_x = first_x_reg;
                cand_y = first_y_reg;
            end
            default:
            begin
                cand_x = cur_x_reg;
                cand_y = cur_y_reg;
            end
        endcase
    end

    // control and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        s_x_next       = s_x_reg;
        s_y_next       = s_y_reg;
        first_x_next   = first_x_reg;
        first_y_next   = first_y_reg;
        last_x_next    = last_x_reg;
        last_y_next    = last_y_reg;
        xp_x_next      = xp_x_reg;
        xp_y_next      = xp_y_reg;
        have_prev_next = have_prev_reg;
        end_next       = end_reg;
        inovf_next     = inovf_reg;
        p_in_next      = p_in_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        prod_next      = prod_reg;
        den_next       = den_reg;
        pb_next        = pb_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dmag_next      = dmag_reg;
        qneg_next      = qneg_reg;
        step_next      = step_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        out_flags_next = out_flags_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        in_ready       = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    end_next   = in_flags.is_end;
                    inovf_next = in_flags.ovf;
                    if (in_flags.has_vtx)
                    begin
                        s_x_next       = cur_x_reg;
                        s_y_next       = cur_y_reg;
                        cur_x_next     = in_x;
                        cur_y_next     = in_y;
                        p_in_next      = tok_in;
                        have_prev_next = 1'b1;
                        if (have_prev_reg && (old_in != tok_in))
                        begin
                            state_next = S_MUL;
                        end
                        else if (tok_in)
                        begin
                            state_next = S_EMITP;
                        end
                        else if (in_flags.is_end)
                        begin
                            state_next = S_ENDCK;
                        end
                    end
                    else if (in_flags.is_end)
                    begin
                        state_next = S_ENDCK;
                    end
                end
            end
            // product and denominator of the crossing
            S_MUL:
            begin
                prod_next  = NW'(d_wa * d_b);
                den_next   = d_a;
                pb_next    = pb;
                state_next = S_DINIT;
            end
            S_DINIT:
            begin
                quo_next   = prod_reg[NW-1] ? NW'(-prod_reg) : NW'(prod_reg);
                dmag_next  = den_reg[CB] ? (CB+1)'(-den_reg) : (CB+1)'(den_reg);
                qneg_next  = prod_reg[NW-1] ^ den_reg[CB];
                rem_next   = '0;
                step_next  = SW'(NW);
                state_next = S_DIV;
            end
            // restoring divide, one quotient bit a cycle
            S_DIV:
            begin
                rem_next  = rem_ge ? (rem_sh - {1'b0, dmag_reg}) : rem_sh;
                quo_next  = {quo_reg[NW-2:0], rem_ge};
                step_next = step_reg - SW'(1);
                if (step_reg == SW'(1))
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                if (AXIS_X)
                begin
                    xp_x_next = win;
                    xp_y_next = s_v[CB-1:0];
                end
                else
                begin
                    xp_x_next = s_v[CB-1:0];
                    xp_y_next = win;
                end
                state_next = S_EMITX;
            end
            S_EMITX, S_EMITP, S_CLOSE:
            begin
                if ((cnt_reg >= CW'(MAX_V)) || out_free)
                begin
                    if (cnt_reg >= CW'(MAX_V))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_flags_next = '{has_vtx: 1'b1, is_end: 1'b0, empty: 1'b0, ovf: 1'b0};
                        out_x_next     = cand_x;
                        out_y_next     = cand_y;
                        cnt_next       = cnt_reg + CW'(1);
                        last_x_next    = cand_x;
                        last_y_next    = cand_y;
                        if (cnt_reg == '0)
                        begin
                            first_x_next = cand_x;
                            first_y_next = cand_y;
                        end
                    end
                    if (state_reg == S_CLOSE)
                    begin
                        state_next = S_SEND;
                    end
                    else if ((state_reg == S_EMITX) && p_in_reg)
                    begin
                        state_next = S_EMITP;
                    end
                    else if (end_reg)
                    begin
                        state_next = S_ENDCK;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            // close the pass output when it does not end on its start
            S_ENDCK:
            begin
                if ((cnt_reg != '0) &&
                    ((first_x_reg != last_x_reg) || (first_y_reg != last_y_reg)))
                begin
                    state_next = S_CLOSE;
                end
                else
                begin
                    state_next = S_SEND;
                end
            end
            S_SEND:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_flags_next = '{has_vtx: 1'b0, is_end: 1'b1,
                                       empty: (cnt_reg == '0), ovf: ovf_reg | inovf_reg};
                    out_x_next     = '0;
                    out_y_next     = '0;
                    cnt_next       = '0;
                    ovf_next       = 1'b0;
                    have_prev_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            have_prev_reg <= 1'b0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            have_prev_reg <= have_prev_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_x_reg     <= cur_x_next;
        cur_y_reg     <= cur_y_next;
        s_x_reg       <= s_x_next;
        s_y_reg       <= s_y_next;
        first_x_reg   <= first_x_next;
        first_y_reg   <= first_y_next;
        last_x_reg    <= last_x_next;
        last_y_reg    <= last_y_next;
        xp_x_reg      <= xp_x_next;
        xp_y_reg      <= xp_y_next;
        end_reg       <= end_next;
        inovf_reg     <= inovf_next;
        p_in_reg      <= p_in_next;
        prod_reg      <= prod_next;
        den_reg       <= den_next;
        pb_reg        <= pb_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        dmag_reg      <= dmag_next;
        qneg_reg      <= qneg_next;
        step_reg      <= step_next;
        out_flags_reg <= out_flags_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
    end

    assign out_valid = out_valid_reg;
    assign out_flags = out_flags_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;

endmodule

// ----- rtl/core/rwpc_obuf.sv -----
module rwpc_obuf #(
    parameter int MAX_V = rwpc_pkg::MAX_VERTICES_DEF,
    parameter int CB    = rwpc_pkg::COORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rwpc_pkg::tok_flags_t in_flags,
    input  logic signed [CB-1:0] in_x,
    input  logic signed [CB-1:0] in_y,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [CB-1:0] out_x,
    output logic signed [CB-1:0] out_y,
    output logic                 out_last,
    output logic                 out_visible,
    output logic                 out_ovf
);

    localparam int AW = $clog2(MAX_V);
    localparam int CW = $clog2(MAX_V + 1);

    typedef enum logic [3:0] {
        B_FILL = 4'b0001,
        B_READ = 4'b0010,
        B_LOAD = 4'b0100,
        B_SHOW = 4'b1000
    } bstate_t;

    bstate_t state_reg, state_next;
    logic [CW-1:0]        wcnt_reg, wcnt_next;
    logic [CW-1:0]        rcnt_reg, rcnt_next;
    logic                 ovf_reg, ovf_next;
    logic                 valid_reg, valid_next;
    logic                 last_reg, last_next;
    logic                 vis_reg, vis_next;
    logic signed [CB-1:0] x_reg, y_reg, x_next, y_next;
    logic                 we;
    logic [2*CB-1:0]      rdata;

    rwpc_ram #(
        .WIDTH(2 * CB),
        .DEPTH(MAX_V)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(wcnt_reg[AW-1:0]),
        .wdata({in_y, in_x}),
        .raddr(rcnt_reg[AW-1:0]),
        .rdata(rdata)
    );

    // collect one clipped polygon, then replay it
    always_comb
    begin
        state_next = state_reg;
        wcnt_next  = wcnt_reg;
        rcnt_next  = rcnt_reg;
        ovf_next   = ovf_reg;
        valid_next = valid_reg;
        last_next  = last_reg;
        vis_next   = vis_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        in_ready   = (state_reg == B_FILL);
        we         = 1'b0;
        case (state_reg)
            B_FILL:
            begin
                if (in_valid)
                begin
                    if (in_flags.has_vtx)
                    begin
                        we        = 1'b1;
                        wcnt_next = wcnt_reg + CW'(1);
                    end
                    else if (in_flags.is_end)
                    begin
                        ovf_next  = in_flags.ovf;
                        rcnt_next = '0;
                        if (in_flags.empty)
                        begin
                            x_next     = '0;
                            y_next     = '0;
                            last_next  = 1'b1;
                            vis_next   = 1'b0;
                            valid_next = 1'b1;
                            state_next = B_SHOW;
                        end
                        else
                        begin
                            state_next = B_READ;
                        end
                    end
                end
            end
            B_READ:
            begin
                state_next = B_LOAD;
            end
            B_LOAD:
            begin
                x_next     = rdata[CB-1:0];
                y_next     = rdata[2*CB-1:CB];
                last_next  = (rcnt_reg == wcnt_reg - CW'(1));
                vis_next   = 1'b1;
                valid_next = 1'b1;
                state_next = B_SHOW;
            end
            B_SHOW:
            begin
                if (out_ready)
                begin
                    valid_next = 1'b0;
                    if (last_reg)
                    begin
                        wcnt_next  = '0;
                        state_next = B_FILL;
                    end
                    else
                    begin
                        rcnt_next  = rcnt_reg + CW'(1);
                        state_next = B_READ;
                    end
                end
            end
            default:
            begin
                state_next = B_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_FILL;
            wcnt_reg  <= '0;
            rcnt_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wcnt_reg  <= wcnt_next;
            rcnt_reg  <= rcnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ovf_reg  <= ovf_next;
        last_reg <= last_next;
        vis_reg  <= vis_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
    end

    assign out_valid   = valid_reg;
    assign out_x       = x_reg;
    assign out_y       = y_reg;
    assign out_last    = last_reg;
    assign out_visible = vis_reg;
    assign out_ovf     = ovf_reg;

endmodule

// ----- rtl/core/rect_window_polygon_clipper_core.sv -----
// Clips a closed polygon against an inclusive rectangular window. Vertices
// enter one beat each, the first vertex repeated as the final beat with tlast
// set. Four clip cells (left, right, top, bottom) sit in a row and pass
// vertices down as they are made; the bottom cell fills a result memory that
// is replayed once the polygon is complete. A vertex that makes a crossing
// goes through the cell's bit-serial divider, and a cell takes no new vertex
// until it is done with the last. Each result is read out of the result
// memory through the read, load and show states. An empty polygon gives one
// result with poly_visible low. Overflow is reported on every result of a
// polygon that exceeded MAX_VERTICES on input or in any pass. The user must
// write window registers only while no polygon is in flight; the block
// itself does not enforce it.
module rect_window_polygon_clipper_core #(
    parameter int MAX_VERTICES = rwpc_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = rwpc_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // vertex_x, vertex_y, zero fill
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]   s_tdata,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_x, out_y, zero fill
    output logic [((2*COORD_BITS+7)/8)*8-1:0]   m_tdata,
    output logic                                m_tlast,
    // poly_visible, overflow
    output logic [1:0]                          m_tuser,
    input  logic                                cfg_we,
    input  logic [rwpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [COORD_BITS-1:0]               cfg_data
);

    localparam int CB = COORD_BITS;
    localparam int DW = ((2 * CB + 7) / 8) * 8;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int NS = rwpc_pkg::NUM_SIDES;

    logic signed [CB-1:0] win_left_reg, win_right_reg, win_top_reg, win_bottom_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 iovf_reg;
    logic signed [CB-1:0] win_arr [NS];

    logic                 c_valid [NS+1];
    logic                 c_ready [NS+1];
    rwpc_pkg::tok_flags_t c_flags [NS+1];
    logic signed [CB-1:0] c_x     [NS+1];
    logic signed [CB-1:0] c_y     [NS+1];

    logic signed [CB-1:0] o_x, o_y;
    logic                 o_last, o_vis, o_ovf;
    logic                 in_room;

    // window registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_left_reg   <= CB'(rwpc_pkg::WIN_LEFT_RST);
            win_right_reg  <= CB'(rwpc_pkg::WIN_RIGHT_RST);
            win_top_reg    <= CB'(rwpc_pkg::WIN_TOP_RST);
            win_bottom_reg <= CB'(rwpc_pkg::WIN_BOTTOM_RST);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rwpc_pkg::REG_WIN_LEFT:   win_left_reg   <= cfg_data;
                rwpc_pkg::REG_WIN_RIGHT:  win_right_reg  <= cfg_data;
                rwpc_pkg::REG_WIN_TOP:    win_top_reg    <= cfg_data;
                rwpc_pkg::REG_WIN_BOTTOM: win_bottom_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign win_arr[rwpc_pkg::SIDE_LEFT]   = win_left_reg;
    assign win_arr[rwpc_pkg::SIDE_RIGHT]  = win_right_reg;
    assign win_arr[rwpc_pkg::SIDE_TOP]    = win_top_reg;
    assign win_arr[rwpc_pkg::SIDE_BOTTOM] = win_bottom_reg;

    // input capacity count; vertices past capacity are dropped
    assign in_room    = cnt_reg < CW'(MAX_VERTICES);
    assign c_valid[0] = s_tvalid;
    assign s_tready   = c_ready[0];
    assign c_flags[0] = '{has_vtx: in_room, is_end: s_tlast, empty: 1'b0,
                          ovf: iovf_reg | !in_room};
    assign c_x[0]     = s_tdata[CB-1:0];
    assign c_y[0]     = s_tdata[2*CB-1:CB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            iovf_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            if (s_tlast)
            begin
                cnt_reg  <= '0;
                iovf_reg <= 1'b0;
            end
            else if (in_room)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else
            begin
                iovf_reg <= 1'b1;
            end
        end
    end

    // row of clip cells, one per window edge
    for (genvar g = 0; g < NS; g++)
    begin : g_cell
        rwpc_cell #(
            .MAX_V(MAX_VERTICES),
            .CB   (CB),
            .SIDE (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .win      (win_arr[g]),
            .in_valid (c_valid[g]),
            .in_ready (c_ready[g]),
            .in_flags (c_flags[g]),
            .in_x     (c_x[g]),
            .in_y     (c_y[g]),
            .out_valid(c_valid[g+1]),
            .out_ready(c_ready[g+1]),
            .out_flags(c_flags[g+1]),
            .out_x    (c_x[g+1]),
            .out_y    (c_y[g+1])
        );
    end

    rwpc_obuf #(
        .MAX_V(MAX_VERTICES),
        .CB   (CB)
    ) u_obuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (c_valid[NS]),
        .in_ready   (c_ready[NS]),
        .in_flags   (c_flags[NS]),
        .in_x       (c_x[NS]),
        .in_y       (c_y[NS]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_x      (o_x),
        .out_y      (o_y),
        .out_last   (o_last),
        .out_visible(o_vis),
        .out_ovf    (o_ovf)
    );

    assign m_tdata = DW'({o_y, o_x});
    assign m_tlast = o_last;
    assign m_tuser = {o_ovf, o_vis};

endmodule

// ----- rtl/core/rwpc_checker.sv -----
module rwpc_checker #(
    parameter int DW = 32
) (
    input logic          clk,
    input logic          rst_n,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic [DW-1:0] m_tdata,
    input logic          m_tlast,
    input logic [1:0]    m_tuser
);

    // an empty polygon is a single closing beat
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("invisible result without tlast");

    // an empty polygon carries zero coordinates
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("invisible result with nonzero data");

    // overflow flag is constant within one polygon
    a_ovf_same: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast ##1 m_tvalid |-> m_tuser[1] == $past(m_tuser[1]))
        else $error("overflow changed inside a polygon");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind rect_window_polygon_clipper_core rwpc_checker #(
    .DW(((2 * COORD_BITS + 7) / 8) * 8)
) u_rwpc_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
);
